@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fbpa_pkg.sv @@
package fbpa_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned INDEX_OUT_W = 6;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned PADDR_W     = 4;
    localparam int unsigned ROW_W       = 8;
    localparam int unsigned ROW_SH      = 3;
    localparam int unsigned DIV_STEPS   = 32;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] REG_BLOCK_COUNT = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE  = 2'd1;
    localparam logic [1:0] REG_DATA_BASE   = 2'd2;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 7'd64;
    localparam logic [DATA_W-1:0]  BLOCK_SIZE_RST  = 32'd64;
    localparam logic [DATA_W-1:0]  DATA_BASE_RST   = 32'd0;

    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] address;
    } fbpa_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [DATA_W-1:0]      block_address;
        logic [INDEX_OUT_W-1:0] block_index;
        logic [COUNT_W-1:0]     used_blocks;
    } fbpa_rsp_t;

    typedef struct packed {
        logic [COUNT_W-1:0] block_count;
        logic [DATA_W-1:0]  block_size;
        logic [DATA_W-1:0]  data_base;
    } fbpa_cfg_t;

    typedef enum logic [1:0] {
        RES_ALLOC,
        RES_FREE,
        RES_FULL,
        RES_BAD
    } fbpa_res_t;

    typedef struct packed {
        logic      clear_wr;
        logic      hint_rd;
        logic      scan_start;
        logic      scan_next;
        logic      scan_take;
        logic      div_start;
        logic      div_step;
        logic      free_rd;
        logic      mul;
        logic      add;
        logic      finish;
        fbpa_res_t res;
    } fbpa_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hint_in_range;
        logic row_bit;
        logic scan_found;
        logic scan_more;
        logic quot_in_range;
        logic size_zero;
        logic rsp_free;
    } fbpa_stat_t;

endpackage

@@ rtl/fbpa_regs.sv @@
module fbpa_regs
    import fbpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output fbpa_cfg_t          cfg
);

    logic [COUNT_W-1:0] block_count_reg, block_count_next;
    logic [DATA_W-1:0]  block_size_reg, block_size_next;
    logic [DATA_W-1:0]  data_base_reg, data_base_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        block_count_next = block_count_reg;
        block_size_next  = block_size_reg;
        data_base_next   = data_base_reg;
        prdata           = '0;
        unique case (paddr[PADDR_W-1:2])
            REG_BLOCK_COUNT:
            begin
                prdata = DATA_W'(block_count_reg);
                if (wr_en)
                begin
                    block_count_next = pwdata[COUNT_W-1:0];
                end
            end
            REG_BLOCK_SIZE:
            begin
                prdata = block_size_reg;
                if (wr_en)
                begin
                    block_size_next = pwdata;
                end
            end
            REG_DATA_BASE:
            begin
                prdata = data_base_reg;
                if (wr_en)
                begin
                    data_base_next = pwdata;
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RST;
            block_size_reg  <= BLOCK_SIZE_RST;
            data_base_reg   <= DATA_BASE_RST;
        end
        else
        begin
            block_count_reg <= block_count_next;
            block_size_reg  <= block_size_next;
            data_base_reg   <= data_base_next;
        end
    end

    assign cfg.block_count = block_count_reg;
    assign cfg.block_size  = block_size_reg;
    assign cfg.data_base   = data_base_reg;

endmodule

@@ rtl/fbpa_ctrl.sv @@
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic       req_command,
    input  fbpa_stat_t stat,
    output fbpa_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_HCHK  = 10'b0000000100,
        S_SCHK  = 10'b0000001000,
        S_MUL   = 10'b0000010000,
        S_ADD   = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_FRD   = 10'b0010000000,
        S_FCHK  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } fbpa_state_t;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    fbpa_state_t          state_reg, state_next;
    fbpa_res_t            res_reg, res_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        div_cnt_next = div_cnt_reg;
        req_ready    = 1'b0;
        cmd          = '0;
        cmd.res      = res_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_command == CMD_ALLOC)
                    begin
                        if (stat.hint_in_range)
                        begin
                            cmd.hint_rd = 1'b1;
                            state_next  = S_HCHK;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCHK;
                        end
                    end
                    else if (stat.size_zero)
                    begin
                        res_next   = RES_BAD;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        div_cnt_next  = '0;
                        state_next    = S_DIV;
                    end
                end
            end
            S_HCHK:
            begin
                if (!stat.row_bit)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (stat.scan_found)
                begin
                    cmd.scan_take = 1'b1;
                    state_next    = S_MUL;
                end
                else if (stat.scan_more)
                begin
                    cmd.scan_next = 1'b1;
                end
                else
                begin
                    res_next   = RES_FULL;
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                res_next   = RES_ALLOC;
                state_next = S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                if (stat.quot_in_range)
                begin
                    cmd.free_rd = 1'b1;
                    state_next  = S_FCHK;
                end
                else
                begin
                    res_next   = RES_BAD;
                    state_next = S_DONE;
                end
            end
            S_FCHK:
            begin
                res_next   = stat.row_bit ? RES_FREE : RES_BAD;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.rsp_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            res_reg     <= RES_BAD;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            res_reg     <= res_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

@@ rtl/fbpa_dp.sv @@
module fbpa_dp
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  fbpa_cfg_t         cfg,
    input  logic [DATA_W-1:0] req_address,
    input  fbpa_cmd_t         cmd,
    output fbpa_stat_t        stat,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output fbpa_rsp_t         rsp
);

    localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
    localparam int unsigned XW     = (IDX_W > ROW_SH) ? IDX_W : ROW_SH + 1;
    localparam int unsigned HW     = XW + 1;
    localparam int unsigned ROW_AW = XW - ROW_SH;
    localparam int unsigned ROWS   = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
    localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);

    // used marks, one row of ROW_W blocks per entry
    logic [ROW_W-1:0]  used_mem [ROWS];
    logic [ROW_W-1:0]  rd_data_reg;
    logic              rd_en;
    logic [ROW_AW-1:0] rd_row;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_row;
    logic [ROW_W-1:0]  wr_data;
    logic [ROW_W-1:0]  bit_mask;

    logic [ROW_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ROW_AW-1:0] scan_row_reg, scan_row_next;
    logic [XW-1:0]     idx_reg, idx_next;
    logic [XW-1:0]     last_reg, last_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [DATA_W-1:0] quot_reg, quot_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0] baddr_reg, baddr_next;
    logic              rsp_valid_reg, rsp_valid_next;
    fbpa_rsp_t         rsp_reg, rsp_next;

    logic [DATA_W-1:0] count_ext;
    logic [HW-1:0]     n_h;
    logic [HW-1:0]     hint;
    logic [HW-1:0]     row_base;
    logic [ROW_W-1:0]  free_vec;
    logic              scan_found;
    logic [ROW_SH-1:0] scan_sel;
    logic [DATA_W:0]   div_shift;
    logic [DATA_W:0]   div_diff;
    logic [XW+INDEX_OUT_W-1:0] idx_wide;
    logic [CNT_W+COUNT_W-1:0]  used_wide;

    assign count_ext = DATA_W'(cfg.block_count);
    assign n_h       = (count_ext < DATA_W'(MAX_BLOCKS)) ? count_ext[HW-1:0] : HW'(MAX_BLOCKS);
    assign hint      = {1'b0, last_reg} + HW'(1);
    assign row_base  = {1'b0, scan_row_reg, {ROW_SH{1'b0}}};

    always_comb
    begin
        for (int j = 0; j < ROW_W; j++)
        begin
            free_vec[j] = ((row_base + HW'(j)) < n_h) && !rd_data_reg[j];
        end
    end

    always_comb
    begin
        scan_found = 1'b0;
        scan_sel   = '0;
        for (int j = ROW_W - 1; j >= 0; j--)
        begin
            if (free_vec[j])
            begin
                scan_found = 1'b1;
                scan_sel   = ROW_SH'(j);
            end
        end
    end

    assign stat.clear_last    = (clr_cnt_reg == ROW_AW'(ROWS - 1));
    assign stat.hint_in_range = (hint < n_h);
    assign stat.row_bit       = rd_data_reg[idx_reg[ROW_SH-1:0]];
    assign stat.scan_found    = scan_found;
    assign stat.scan_more     = ((row_base + HW'(ROW_W)) < n_h);
    assign stat.quot_in_range = (quot_reg[DATA_W-1:HW] == '0) && (quot_reg[HW-1:0] < n_h);
    assign stat.size_zero     = (cfg.block_size == '0);
    assign stat.rsp_free      = !rsp_valid_reg || rsp_ready;

    // memory port selection
    always_comb
    begin
        rd_en  = cmd.hint_rd || cmd.scan_start || cmd.scan_next || cmd.free_rd;
        rd_row = '0;
        if (cmd.hint_rd)
        begin
            rd_row = hint[XW-1:ROW_SH];
        end
        else if (cmd.scan_next)
        begin
            rd_row = scan_row_reg + ROW_AW'(1);
        end
        else if (cmd.free_rd)
        begin
            rd_row = quot_reg[XW-1:ROW_SH];
        end
    end

    assign bit_mask = ROW_W'(1) << idx_reg[ROW_SH-1:0];

    always_comb
    begin
        wr_en   = cmd.clear_wr ||
                  (cmd.finish && (cmd.res == RES_ALLOC || cmd.res == RES_FREE));
        wr_row  = cmd.clear_wr ? clr_cnt_reg : idx_reg[XW-1:ROW_SH];
        wr_data = '0;
        if (!cmd.clear_wr)
        begin
            wr_data = (cmd.res == RES_ALLOC) ? (rd_data_reg | bit_mask)
                                             : (rd_data_reg & ~bit_mask);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            used_mem[wr_row] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= used_mem[rd_row];
        end
    end

    // index, scan and divider
    assign div_shift = {rem_reg, quot_reg[DATA_W-1]};
    assign div_diff  = div_shift - {1'b0, cfg.block_size};

    always_comb
    begin
        clr_cnt_next  = cmd.clear_wr ? clr_cnt_reg + ROW_AW'(1) : clr_cnt_reg;
        scan_row_next = scan_row_reg;
        if (cmd.scan_start)
        begin
            scan_row_next = '0;
        end
        else if (cmd.scan_next)
        begin
            scan_row_next = scan_row_reg + ROW_AW'(1);
        end

        idx_next = idx_reg;
        if (cmd.hint_rd)
        begin
            idx_next = hint[XW-1:0];
        end
        else if (cmd.scan_take)
        begin
            idx_next = {scan_row_reg, scan_sel};
        end
        else if (cmd.free_rd)
        begin
            idx_next = quot_reg[XW-1:0];
        end

        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (cmd.div_start)
        begin
            quot_next = req_address - cfg.data_base;
            rem_next  = '0;
        end
        else if (cmd.div_step)
        begin
            if (!div_diff[DATA_W])
            begin
                rem_next  = div_diff[DATA_W-1:0];
                quot_next = {quot_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = div_shift[DATA_W-1:0];
                quot_next = {quot_reg[DATA_W-2:0], 1'b0};
            end
        end

        prod_next  = cmd.mul ? cfg.block_size * DATA_W'(idx_reg) : prod_reg;
        baddr_next = cmd.add ? cfg.data_base + prod_reg : baddr_reg;
    end

    // commit and result word
    always_comb
    begin
        last_next = last_reg;
        used_next = used_reg;
        if (cmd.finish && cmd.res == RES_ALLOC)
        begin
            last_next = idx_reg;
            used_next = used_reg + CNT_W'(1);
        end
        else if (cmd.finish && cmd.res == RES_FREE)
        begin
            used_next = used_reg - CNT_W'(1);
        end
    end

    assign idx_wide  = {{INDEX_OUT_W{1'b0}}, idx_reg};
    assign used_wide = {{COUNT_W{1'b0}}, used_next};

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.used_blocks = used_wide[COUNT_W-1:0];
        case (cmd.res)
            RES_ALLOC:
            begin
                rsp_next.status        = ST_OK;
                rsp_next.block_address = baddr_reg;
                rsp_next.block_index   = idx_wide[INDEX_OUT_W-1:0];
            end
            RES_FREE:
            begin
                rsp_next.status      = ST_OK;
                rsp_next.block_index = idx_wide[INDEX_OUT_W-1:0];
            end
            RES_FULL:
            begin
                rsp_next.status = ST_FULL;
            end
            default:
            begin
                rsp_next.status = ST_BAD_FREE;
            end
        endcase
    end

    assign rsp_valid_next = cmd.finish || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            last_reg      <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            last_reg      <= last_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_row_reg <= scan_row_next;
        idx_reg      <= idx_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        prod_reg     <= prod_next;
        baddr_reg    <= baddr_next;
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/fixed_block_pool_allocator.sv @@
// Fixed-size block pool allocator. One request word is handled at a time; a new
// one is taken as soon as the previous has been committed, while its response
// word may still be waiting. The used marks sit in a memory of 8-block rows, so
// after reset a clearing pass over every row runs with req_ready low (register
// writes are taken meanwhile). An allocate takes the hinted block if it is
// free; otherwise a first-free scan examines the 8-block rows in turn, and when
// the hint is out of range its check is skipped. A free runs the radix-2 divider
// that maps the address offset to an index (32 steps) and fails when the index
// is out of range. A zero block size fails a free.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               req_valid,
    output logic               req_ready,
    input  fbpa_req_t          req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output fbpa_rsp_t          rsp
);

    fbpa_cfg_t  cfg;
    fbpa_cmd_t  cmd;
    fbpa_stat_t stat;

    fbpa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fbpa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_command (req.command),
        .stat        (stat),
        .cmd         (cmd)
    );

    fbpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req_address (req.address),
        .cmd         (cmd),
        .stat        (stat),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule

@@ rtl/fbpa_checker.sv @@
`include "assert_macros.svh"

module fbpa_checker
    import fbpa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input fbpa_rsp_t          rsp
);

    // a failed request never reports a block
    `ASSERT_IMPLY(a_fail_no_block, clk, rst_n, rsp_valid && rsp.status != ST_OK, rsp.block_address == '0 && rsp.block_index == '0, "failed request reports a block")

    // one request in flight at a time
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while busy")

    // stalled response word holds
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
